[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/prlc_pkg.sv]
// Constants and register indexes for the ramp-limited PID controller
`timescale 1ns / 1ps

package prlc_pkg;

  localparam int DATA_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int FRAC     = 8;
  localparam int TIME_W   = 10;
  localparam int CFG_IDX_W = 3;

  localparam int ERR_W    = DATA_W + 1;
  localparam int KDT_W    = GAIN_W + TIME_W + 1;
  localparam int QUO_W    = DATA_W + FRAC;
  localparam int DER_W    = QUO_W + 1;
  localparam int PROD_W   = KDT_W + ERR_W;
  localparam int INTEG_W  = DATA_W + FRAC;
  localparam int ISUM_W   = PROD_W + 1;
  localparam int SUM_W    = GAIN_W + ERR_W + 2;
  localparam int QSUM_W   = SUM_W - FRAC;
  localparam int RAMP_W   = DATA_W + 2;
  localparam int CNT_W    = $clog2(QUO_W);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP   = 3'd6;

  localparam logic ACT_CLEAR = 1'b1;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST  = 16'sd256;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = -16'sd32768;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 16'sd32767;

endpackage

[rtl/core/pid_ramp_limited_controller.sv]
// PID step engine: shared multiplier, serial divider, clamp and ramp limit
// Sequence: a run word passes S_KIDT, S_KIE, S_INT, S_DIV (the 24-step restoring
//   divider), S_KP, S_PSUM, S_KD, S_DSUM, S_CLAMP, S_RAMP and S_OUT; clear, disabled
//   and zero-time words go straight to S_OUT. Throughput: one word at a time;
//   a result held back by the receiver keeps in_ready low until the slot frees.
// Reset: synchronous, active high; config to defaults, integral and history zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pid_ramp_limited_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [prlc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [prlc_pkg::DATA_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic signed [prlc_pkg::DATA_W-1:0]    target,
  input  logic signed [prlc_pkg::DATA_W-1:0]    measured,
  input  logic [prlc_pkg::TIME_W-1:0]           elapsed_ms,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [prlc_pkg::DATA_W-1:0]    drive,
  output logic                                  updated
);

  localparam int DATA_W  = prlc_pkg::DATA_W;
  localparam int GAIN_W  = prlc_pkg::GAIN_W;
  localparam int FRAC    = prlc_pkg::FRAC;
  localparam int TIME_W  = prlc_pkg::TIME_W;
  localparam int ERR_W   = prlc_pkg::ERR_W;
  localparam int KDT_W   = prlc_pkg::KDT_W;
  localparam int QUO_W   = prlc_pkg::QUO_W;
  localparam int DER_W   = prlc_pkg::DER_W;
  localparam int PROD_W  = prlc_pkg::PROD_W;
  localparam int INTEG_W = prlc_pkg::INTEG_W;
  localparam int ISUM_W  = prlc_pkg::ISUM_W;
  localparam int SUM_W   = prlc_pkg::SUM_W;
  localparam int QSUM_W  = prlc_pkg::QSUM_W;
  localparam int RAMP_W  = prlc_pkg::RAMP_W;
  localparam int CNT_W   = prlc_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_KIDT, S_KIE, S_INT, S_DIV, S_KP, S_PSUM, S_KD, S_DSUM,
    S_CLAMP, S_RAMP, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic                       enable;
  logic signed [GAIN_W-1:0]   gain_p, gain_i, gain_d;
  logic signed [DATA_W-1:0]   out_min, out_max;
  logic [DATA_W-1:0]          ramp_limit;

  // controller state
  logic signed [INTEG_W-1:0]  integ;
  logic signed [DATA_W-1:0]   last_meas;
  logic signed [DATA_W-1:0]   last_drive;

  // working registers
  logic signed [ERR_W-1:0]    err;
  logic signed [DATA_W-1:0]   meas_r;
  logic [TIME_W-1:0]          dt;
  logic signed [PROD_W-1:0]   prod;
  logic [QUO_W-1:0]           quo;
  logic [TIME_W-1:0]          rem;
  logic                       div_neg;
  logic [CNT_W-1:0]           div_cnt;
  logic signed [DER_W-1:0]    deriv;
  logic signed [SUM_W-1:0]    sum;
  logic signed [DATA_W-1:0]   drive_c;
  logic signed [DATA_W-1:0]   res_drive;
  logic                       res_upd;
  logic                       run_item;

  // shared multiplier
  logic signed [KDT_W-1:0]        mul_a;
  logic signed [DER_W-1:0]        mul_b;
  logic signed [KDT_W+DER_W-1:0]  mul_full;

  always_comb begin
    unique case (state)
      S_KIDT: begin
        mul_a = KDT_W'(gain_i);
        mul_b = $signed({{(DER_W-TIME_W){1'b0}}, dt});
      end
      S_KIE: begin
        mul_a = prod[KDT_W-1:0];
        mul_b = DER_W'(err);
      end
      S_KP: begin
        mul_a = KDT_W'(gain_p);
        mul_b = DER_W'(err);
      end
      S_KD: begin
        mul_a = KDT_W'(gain_d);
        mul_b = deriv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // integral update with clamp, lower limit first
  logic signed [ISUM_W-1:0] isum, ilo, ihi;
  assign isum = ISUM_W'(integ) + ISUM_W'(prod);
  assign ilo  = ISUM_W'($signed({out_min, {FRAC{1'b0}}}));
  assign ihi  = ISUM_W'($signed({out_max, {FRAC{1'b0}}}));

  // derivative difference and one divider step
  logic signed [ERR_W-1:0]  mdiff;
  logic [ERR_W-1:0]         mmag;
  logic [TIME_W:0]          rem_sh, rem_sub;
  assign mdiff   = ERR_W'(meas_r) - ERR_W'(last_meas);
  assign mmag    = mdiff[ERR_W-1] ? ERR_W'(-mdiff) : mdiff;
  assign rem_sh  = {rem, quo[QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, dt};

  // output clamp and ramp limit
  logic signed [QSUM_W-1:0] qsum;
  logic signed [RAMP_W-1:0] change, ramp_s, ld_s, ramped;
  assign qsum   = sum[SUM_W-1:FRAC];
  assign ld_s   = RAMP_W'(last_drive);
  assign change = RAMP_W'(drive_c) - ld_s;
  assign ramp_s = $signed({2'b00, ramp_limit});

  always_comb begin
    priority if (ramp_limit != '0 && change > ramp_s) begin
      ramped = ld_s + ramp_s;
    end else if (ramp_limit != '0 && change < -ramp_s) begin
      ramped = ld_s - ramp_s;
    end else begin
      ramped = RAMP_W'(drive_c);
    end
  end

  logic slot_free;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      gain_p     <= prlc_pkg::GAIN_P_RST;
      gain_i     <= '0;
      gain_d     <= '0;
      out_min    <= prlc_pkg::OUT_MIN_RST;
      out_max    <= prlc_pkg::OUT_MAX_RST;
      ramp_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prlc_pkg::REG_ENABLE:  enable     <= cfg_data[0];
        prlc_pkg::REG_GAIN_P:  gain_p     <= $signed(cfg_data);
        prlc_pkg::REG_GAIN_I:  gain_i     <= $signed(cfg_data);
        prlc_pkg::REG_GAIN_D:  gain_d     <= $signed(cfg_data);
        prlc_pkg::REG_OUT_MIN: out_min    <= $signed(cfg_data);
        prlc_pkg::REG_OUT_MAX: out_max    <= $signed(cfg_data);
        prlc_pkg::REG_RAMP:    ramp_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      integ      <= '0;
      last_meas  <= '0;
      last_drive <= '0;
      out_valid  <= 1'b0;
      run_item   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            err       <= ERR_W'(target) - ERR_W'(measured);
            meas_r    <= measured;
            dt        <= elapsed_ms;
            res_drive <= '0;
            run_item  <= 1'b0;
            if (action == prlc_pkg::ACT_CLEAR) begin
              integ     <= '0;
              last_meas <= '0;
              res_upd   <= 1'b1;
              state     <= S_OUT;
            end else if (!enable || elapsed_ms == '0) begin
              res_upd <= 1'b0;
              state   <= S_OUT;
            end else begin
              run_item <= 1'b1;
              state    <= S_KIDT;
            end
          end
        end
        S_KIDT: begin
          prod  <= PROD_W'(mul_full);
          state <= S_KIE;
        end
        S_KIE: begin
          prod  <= PROD_W'(mul_full);
          state <= S_INT;
        end
        S_INT: begin
          priority if (isum < ilo) begin
            integ <= $signed({out_min, {FRAC{1'b0}}});
          end else if (isum > ihi) begin
            integ <= $signed({out_max, {FRAC{1'b0}}});
          end else begin
            integ <= isum[INTEG_W-1:0];
          end
          quo     <= {mmag[DATA_W-1:0], {FRAC{1'b0}}};
          rem     <= '0;
          div_neg <= mdiff[ERR_W-1];
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (!rem_sub[TIME_W]) begin
            rem <= rem_sub[TIME_W-1:0];
            quo <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[TIME_W-1:0];
            quo <= {quo[QUO_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(QUO_W - 1)) state <= S_KP;
        end
        S_KP: begin
          deriv <= div_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
          prod  <= PROD_W'(mul_full);
          state <= S_PSUM;
        end
        S_PSUM: begin
          sum   <= prod[SUM_W-1:0] + SUM_W'(integ);
          state <= S_KD;
        end
        S_KD: begin
          prod  <= PROD_W'(mul_full);
          state <= S_DSUM;
        end
        S_DSUM: begin
          sum   <= sum - $signed(prod[FRAC+SUM_W-1:FRAC]);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          priority if (qsum < QSUM_W'(out_min)) begin
            drive_c <= out_min;
          end else if (qsum > QSUM_W'(out_max)) begin
            drive_c <= out_max;
          end else begin
            drive_c <= qsum[DATA_W-1:0];
          end
          state <= S_RAMP;
        end
        S_RAMP: begin
          res_drive  <= ramped[DATA_W-1:0];
          res_upd    <= 1'b1;
          last_drive <= ramped[DATA_W-1:0];
          last_meas  <= meas_r;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            drive     <= res_drive;
            updated   <= res_upd;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_clear_zeroes, in_valid && in_ready && action == prlc_pkg::ACT_CLEAR |=> integ == '0 && last_meas == '0, "clear left state")
  `ASSERT_CLK(a_skip_holds, in_valid && in_ready && action != prlc_pkg::ACT_CLEAR && (!enable || elapsed_ms == '0) |=> $stable(integ) && $stable(last_meas) && $stable(last_drive), "skipped word changed state")
  `ASSERT_CLK(a_drive_tracks, state == S_OUT && slot_free && run_item |=> drive == last_drive && updated, "drive differs from last drive")
  `ASSERT_ALWAYS(a_busy_no_out_load, state != S_OUT && state != S_IDLE |-> !in_ready, "ready while busy")

endmodule
